// File: rtl/core/rpsm_pkg.sv
`timescale 1ns / 1ps

package rpsm_pkg;

    localparam int unsigned NUM_W     = 28;
    localparam int unsigned DEN_W     = 16;
    localparam int unsigned DIV_STEPS = NUM_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
    localparam int unsigned SPEED_W   = 24;
    localparam int unsigned PROD_W    = 18;

    localparam logic [NUM_W-1:0]   SPEED_SCALE = NUM_W'(1000);
    localparam logic [SPEED_W-1:0] SPEED_MIN   = SPEED_W'(5);
    localparam logic [SPEED_W-1:0] SPEED_MAX   = {SPEED_W{1'b1}};

    localparam logic [7:0] REG_FILTER_TICKS   = 8'd0;
    localparam logic [7:0] REG_IDLE_LEVELS    = 8'd1;
    localparam logic [7:0] REG_RESET_NEEDED   = 8'd2;
    localparam logic [7:0] REG_RESET_WINDOW   = 8'd3;
    localparam logic [7:0] REG_SPEED_PULSES   = 8'd4;
    localparam logic [7:0] REG_SPEED_TIMEOUT  = 8'd5;
    localparam logic [7:0] REG_GRID_LENGTH    = 8'd6;
    localparam logic [7:0] REG_START_POSITION = 8'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        armed;
        logic        prev;
        logic [15:0] cnt;
        logic        pulse;
    } filt_t;

    // one tick of the re-armable glitch filter
    function automatic filt_t filter_step(input logic armed, input logic prev,
                                          input logic [15:0] cnt, input logic level,
                                          input logic idle, input logic [15:0] ticks);
        filt_t f;
        f.armed = armed;
        f.prev  = prev;
        f.cnt   = cnt;
        f.pulse = 1'b0;
        if (f.armed) begin
            f.prev = level;
            if (level == idle) begin
                f.armed = 1'b0;
                f.cnt   = '0;
            end
        end
        if (!f.armed && level != f.prev) begin
            f.cnt = f.cnt + 16'd1;
            if (f.cnt >= ticks) begin
                f.armed = 1'b1;
                f.cnt   = '0;
                f.pulse = 1'b1;
            end
        end
        return f;
    endfunction

endpackage

// File: rtl/core/rpsm_div.sv
`timescale 1ns / 1ps

module rpsm_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [rpsm_pkg::NUM_W-1:0]       dividend,
    input  logic [rpsm_pkg::DEN_W-1:0]       divisor,
    output logic                             done,
    output logic [rpsm_pkg::NUM_W-1:0]       quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [rpsm_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [rpsm_pkg::NUM_W-1:0]      quo_reg, quo_next;
    logic [rpsm_pkg::DEN_W-1:0]      rem_reg, rem_next;
    logic [rpsm_pkg::DEN_W-1:0]      den_reg, den_next;
    logic [rpsm_pkg::DEN_W:0]        trial;
    logic [rpsm_pkg::DEN_W:0]        diff;
    logic                            ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[rpsm_pkg::NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[rpsm_pkg::NUM_W-2:0], ge};
            rem_next = ge ? diff[rpsm_pkg::DEN_W-1:0] : trial[rpsm_pkg::DEN_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == rpsm_pkg::STEP_W'(rpsm_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/raster_position_speed_meter.sv
`timescale 1ns / 1ps
// Grating position and speed meter, one transaction per timer tick.
// s_ channel: one transaction carries the sampled reset and count grating levels.
// m_ channel: one result per tick with the position after the tick, the last speed,
// and flags for a position clear and for a closed speed measurement.
// cfg channel: register writes (index, data), always ready, to be written only while
// no tick is in work; writing start_position also loads the position. Unknown
// indexes are ignored.
// Flow: the filters, reset window and position update in the accept cycle; a
// tick that closes no speed measurement goes straight to the final stage, and the
// block takes the next tick once that stage has handed its result to the output
// register. A tick that closes a measurement runs grid_length*pulses, then *1000,
// then a shift-subtract divide by the elapsed ticks, one quotient bit per cycle,
// before it reaches the final stage.
// s_ready is high only while no tick is in work. A finished result sits in the
// output register; a new tick is accepted while it waits, and its own result
// waits in the final stage until m_ready frees the output register.
// Reset (aresetn low, synchronous) restores register defaults, disarms both
// filters, clears counters, position and speed, and empties the output.

module raster_position_speed_meter (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_reset_level,
    input  logic                         s_count_level,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [31:0]                  m_position,
    output logic [rpsm_pkg::SPEED_W-1:0] m_speed,
    output logic                         m_zeroed,
    output logic                         m_speed_updated,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [7:0]                   cfg_index,
    input  logic [31:0]                  cfg_data
);

    // configuration
    logic [15:0] filter_ticks_reg;
    logic [1:0]  idle_levels_reg;
    logic [3:0]  reset_needed_reg;
    logic [15:0] reset_window_reg;
    logic [7:0]  speed_pulses_reg;
    logic [15:0] speed_timeout_reg;
    logic [9:0]  grid_length_reg;

    // tick state
    rpsm_pkg::filt_t rf_cur, cf_cur, rf_tick, cf_tick;
    logic        r_armed_reg, r_armed_next;
    logic        r_prev_reg, r_prev_next;
    logic [15:0] r_cnt_reg, r_cnt_next;
    logic        c_armed_reg, c_armed_next;
    logic        c_prev_reg, c_prev_next;
    logic [15:0] c_cnt_reg, c_cnt_next;
    logic [7:0]  rpc_reg, rpc_next;
    logic [16:0] rwt_reg, rwt_next;
    logic [7:0]  spc_reg, spc_next;
    logic [15:0] st_reg, st_next;
    logic [31:0] position_reg, position_next;
    logic [rpsm_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic        zeroed_reg, zeroed_next;
    logic        updated_reg, updated_next;
    logic [7:0]  spc_op_reg, spc_op_next;
    logic [15:0] st_op_reg, st_op_next;
    logic [rpsm_pkg::PROD_W-1:0] prod_reg;
    logic [rpsm_pkg::NUM_W-1:0]  num_reg;
    logic        close;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_position_reg;
    logic [rpsm_pkg::SPEED_W-1:0] m_speed_reg;
    logic        m_zeroed_reg;
    logic        m_updated_reg;

    rpsm_pkg::state_t state_reg, state_next;
    logic        accept;
    logic        div_start;
    logic        div_done;
    logic [rpsm_pkg::NUM_W-1:0] div_quo;
    logic        out_free;
    logic        load_out;
    logic [rpsm_pkg::SPEED_W-1:0] speed_sat;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rpsm_pkg::ST_IDLE:  if (accept) state_next = close ? rpsm_pkg::ST_MUL
                                                               : rpsm_pkg::ST_DONE;
            rpsm_pkg::ST_MUL:   state_next = rpsm_pkg::ST_SCALE;
            rpsm_pkg::ST_SCALE: state_next = rpsm_pkg::ST_START;
            rpsm_pkg::ST_START: state_next = rpsm_pkg::ST_DIV;
            rpsm_pkg::ST_DIV:   if (div_done) state_next = rpsm_pkg::ST_DONE;
            rpsm_pkg::ST_DONE:  if (out_free) state_next = rpsm_pkg::ST_IDLE;
            default:            state_next = rpsm_pkg::ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            rpsm_pkg::ST_IDLE:  s_ready = 1'b1;
            rpsm_pkg::ST_START: div_start = 1'b1;
            rpsm_pkg::ST_DONE:  load_out = out_free;
            default: ;
        endcase
    end

    // filter evaluation for the incoming tick
    always_comb begin
        rf_tick = rpsm_pkg::filter_step(r_armed_reg, r_prev_reg, r_cnt_reg, s_reset_level,
                                        idle_levels_reg[0], filter_ticks_reg);
        cf_tick = rpsm_pkg::filter_step(c_armed_reg, c_prev_reg, c_cnt_reg, s_count_level,
                                        idle_levels_reg[1], filter_ticks_reg);
    end

    // tick update: reset grating first, then count grating and speed window
    always_comb begin
        rf_cur        = rf_tick;
        cf_cur        = cf_tick;
        rpc_next      = rpc_reg;
        rwt_next      = rwt_reg;
        spc_next      = spc_reg;
        st_next       = st_reg;
        position_next = position_reg;
        zeroed_next   = 1'b0;
        updated_next  = 1'b0;
        spc_op_next   = spc_reg;
        st_op_next    = st_reg;
        close         = 1'b0;

        if (rf_cur.pulse) begin
            if (rpc_next != 8'hFF) rpc_next = rpc_next + 8'd1;
            if (rpc_next >= {4'b0, reset_needed_reg} && rwt_next < {1'b0, reset_window_reg}) begin
                position_next = '0;
                rpc_next      = '0;
                rwt_next      = '0;
                zeroed_next   = 1'b1;
            end
        end
        if (rpc_next != 8'd0) begin
            if (rwt_next != 17'h1FFFF) rwt_next = rwt_next + 17'd1;
            // window ran out: drop the partial count and force a re-arm
            if (rwt_next > {1'b0, reset_window_reg}) begin
                rpc_next     = '0;
                rwt_next     = '0;
                rf_cur.armed = 1'b1;
            end
        end

        if (cf_cur.pulse) begin
            position_next = position_next + 32'd1;
            if (spc_next != 8'hFF) spc_next = spc_next + 8'd1;
        end
        if (st_next != 16'hFFFF) st_next = st_next + 16'd1;
        if (spc_next >= speed_pulses_reg || st_next >= speed_timeout_reg) begin
            close        = 1'b1;
            spc_op_next  = spc_next;
            st_op_next   = st_next;
            spc_next     = '0;
            st_next      = '0;
            updated_next = 1'b1;
        end

        r_armed_next = rf_cur.armed;
        r_prev_next  = rf_cur.prev;
        r_cnt_next   = rf_cur.cnt;
        c_armed_next = cf_cur.armed;
        c_prev_next  = cf_cur.prev;
        c_cnt_next   = cf_cur.cnt;
    end

    rpsm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (st_op_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        if (div_quo > rpsm_pkg::NUM_W'(rpsm_pkg::SPEED_MAX)) speed_sat = rpsm_pkg::SPEED_MAX;
        else speed_sat = div_quo[rpsm_pkg::SPEED_W-1:0];
        if (speed_sat < rpsm_pkg::SPEED_MIN) speed_sat = '0;
        speed_next = (state_reg == rpsm_pkg::ST_DIV && div_done) ? speed_sat : speed_reg;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= rpsm_pkg::ST_IDLE;
            filter_ticks_reg   <= 16'd1;
            idle_levels_reg    <= 2'd3;
            reset_needed_reg   <= 4'd2;
            reset_window_reg   <= 16'd1000;
            speed_pulses_reg   <= 8'd10;
            speed_timeout_reg  <= 16'd1000;
            grid_length_reg    <= 10'd10;
            r_armed_reg        <= 1'b0;
            r_prev_reg         <= 1'b0;
            r_cnt_reg          <= '0;
            c_armed_reg        <= 1'b0;
            c_prev_reg         <= 1'b0;
            c_cnt_reg          <= '0;
            rpc_reg            <= '0;
            rwt_reg            <= '0;
            spc_reg            <= '0;
            st_reg             <= '0;
            position_reg       <= '0;
            speed_reg          <= '0;
            zeroed_reg         <= 1'b0;
            updated_reg        <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg   <= state_next;
            speed_reg   <= speed_next;
            m_valid_reg <= m_valid_next;
            // a preset write loads the position
            if (cfg_valid && cfg_index == rpsm_pkg::REG_START_POSITION)
                position_reg <= cfg_data;
            else if (accept)
                position_reg <= position_next;
            if (accept) begin
                r_armed_reg  <= r_armed_next;
                r_prev_reg   <= r_prev_next;
                r_cnt_reg    <= r_cnt_next;
                c_armed_reg  <= c_armed_next;
                c_prev_reg   <= c_prev_next;
                c_cnt_reg    <= c_cnt_next;
                rpc_reg      <= rpc_next;
                rwt_reg      <= rwt_next;
                spc_reg      <= spc_next;
                st_reg       <= st_next;
                zeroed_reg   <= zeroed_next;
                updated_reg  <= updated_next;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    rpsm_pkg::REG_FILTER_TICKS:   filter_ticks_reg  <= cfg_data[15:0];
                    rpsm_pkg::REG_IDLE_LEVELS:    idle_levels_reg   <= cfg_data[1:0];
                    rpsm_pkg::REG_RESET_NEEDED:   reset_needed_reg  <= cfg_data[3:0];
                    rpsm_pkg::REG_RESET_WINDOW:   reset_window_reg  <= cfg_data[15:0];
                    rpsm_pkg::REG_SPEED_PULSES:   speed_pulses_reg  <= cfg_data[7:0];
                    rpsm_pkg::REG_SPEED_TIMEOUT:  speed_timeout_reg <= cfg_data[15:0];
                    rpsm_pkg::REG_GRID_LENGTH:    grid_length_reg   <= cfg_data[9:0];
                    rpsm_pkg::REG_START_POSITION: ;
                    default: ;
                endcase
            end
        end
    end

    // operand and output payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            spc_op_reg <= spc_op_next;
            st_op_reg  <= st_op_next;
        end
        if (state_reg == rpsm_pkg::ST_MUL)
            prod_reg <= rpsm_pkg::PROD_W'(grid_length_reg) * rpsm_pkg::PROD_W'(spc_op_reg);
        if (state_reg == rpsm_pkg::ST_SCALE)
            num_reg <= rpsm_pkg::NUM_W'(prod_reg) * rpsm_pkg::SPEED_SCALE;
        if (load_out) begin
            m_position_reg <= position_reg;
            m_speed_reg    <= speed_reg;
            m_zeroed_reg   <= zeroed_reg;
            m_updated_reg  <= updated_reg;
        end
    end

    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_position      = m_position_reg;
    assign m_speed         = m_speed_reg;
    assign m_zeroed        = m_zeroed_reg;
    assign m_speed_updated = m_updated_reg;

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("tick accepted while another is in work");

    a_speed_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_speed == '0 || m_speed >= rpsm_pkg::SPEED_MIN))
        else $error("speed below floor not forced to zero");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == rpsm_pkg::ST_DIV)
        else $error("divider finished outside divide state");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten");

endmodule

// File: sim/raster_position_speed_meter_tb.sv
`timescale 1ns / 1ps

module raster_position_speed_meter_tb;

    localparam logic [7:0] REG_NONE_FIRST = 8'd8;
    localparam logic [7:0] REG_NONE_LAST  = 8'd255;

    // directed ticks, first tick in the top bits: {reset_level, count_level}
    localparam logic [47:0] DIRECTED_LEVELS =
        48'b00_11_11_00_00_11_01_10_11_00_11_00_11_00_11_00_11_00_11_00_11_01_11_10;

    typedef struct {
        bit [31:0]                  position;
        bit [rpsm_pkg::SPEED_W-1:0] speed;
        bit                         zeroed;
        bit                         speed_updated;
    } tick_result_t;

    class position_speed_board;
        bit [15:0]        filter_ticks;
        bit [1:0]         idle_levels;
        bit [3:0]         reset_needed;
        bit [15:0]        reset_window;
        bit [7:0]         speed_pulses;
        bit [15:0]        speed_timeout;
        bit [9:0]         grid_length;
        bit [31:0]        start_position;

        bit               rst_armed;
        bit               rst_prev;
        bit [15:0]        rst_cnt;
        bit               cnt_armed;
        bit               cnt_prev;
        bit [15:0]        cnt_cnt;
        bit [7:0]         reset_hits;
        bit [16:0]        window_timer;
        bit [7:0]         speed_hits;
        bit [15:0]        speed_timer;
        bit [31:0]        position;
        bit [rpsm_pkg::SPEED_W-1:0] speed;

        tick_result_t     expected_ticks[$];
        int               errors;

        function new();
            filter_ticks   = 16'd1;
            idle_levels    = 2'd3;
            reset_needed   = 4'd2;
            reset_window   = 16'd1000;
            speed_pulses   = 8'd10;
            speed_timeout  = 16'd1000;
            grid_length    = 10'd10;
            start_position = 32'd0;
            rst_armed      = 1'b0;
            rst_prev       = 1'b0;
            rst_cnt        = '0;
            cnt_armed      = 1'b0;
            cnt_prev       = 1'b0;
            cnt_cnt        = '0;
            reset_hits     = '0;
            window_timer   = '0;
            speed_hits     = '0;
            speed_timer    = '0;
            position       = 32'd0;
            speed          = '0;
            errors         = 0;
        endfunction

        function void write_reg(bit [7:0] idx, bit [31:0] data);
            case (idx)
                rpsm_pkg::REG_FILTER_TICKS:   filter_ticks  = data[15:0];
                rpsm_pkg::REG_IDLE_LEVELS:    idle_levels   = data[1:0];
                rpsm_pkg::REG_RESET_NEEDED:   reset_needed  = data[3:0];
                rpsm_pkg::REG_RESET_WINDOW:   reset_window  = data[15:0];
                rpsm_pkg::REG_SPEED_PULSES:   speed_pulses  = data[7:0];
                rpsm_pkg::REG_SPEED_TIMEOUT:  speed_timeout = data[15:0];
                rpsm_pkg::REG_GRID_LENGTH:    grid_length   = data[9:0];
                rpsm_pkg::REG_START_POSITION: begin
                    start_position = data;
                    position       = data;
                end
                default: ;
            endcase
        endfunction

        // re-armable glitch filter, returns 1 on an accepted pulse
        function bit glitch_filter(inout bit armed, inout bit prev, inout bit [15:0] cnt,
                                   input bit level, input bit idle);
            bit hit;
            hit = 1'b0;
            if (armed) begin
                prev = level;
                if (level == idle) begin
                    armed = 1'b0;
                    cnt   = '0;
                end
            end
            if (!armed && level != prev) begin
                cnt = cnt + 16'd1;
                if (cnt >= filter_ticks) begin
                    armed = 1'b1;
                    cnt   = '0;
                    hit   = 1'b1;
                end
            end
            return hit;
        endfunction

        function void note_tick(bit rlev, bit clev);
            tick_result_t exp;
            bit [63:0]    quot;
            exp.zeroed        = 1'b0;
            exp.speed_updated = 1'b0;

            // reset grating goes first, so a count pulse on the zeroing tick gives 1
            if (glitch_filter(rst_armed, rst_prev, rst_cnt, rlev, idle_levels[0])) begin
                if (reset_hits != 8'hFF)
                    reset_hits = reset_hits + 8'd1;
                if (reset_hits >= reset_needed && window_timer < reset_window) begin
                    position     = 32'd0;
                    reset_hits   = '0;
                    window_timer = '0;
                    exp.zeroed   = 1'b1;
                end
            end
            if (reset_hits != 0) begin
                if (window_timer != 17'h1FFFF)
                    window_timer = window_timer + 17'd1;
                // window ran out: drop the pulses even if enough had come
                if (window_timer > reset_window) begin
                    reset_hits   = '0;
                    window_timer = '0;
                    rst_armed    = 1'b1;
                end
            end

            if (glitch_filter(cnt_armed, cnt_prev, cnt_cnt, clev, idle_levels[1])) begin
                position = position + 32'd1;
                if (speed_hits != 8'hFF)
                    speed_hits = speed_hits + 8'd1;
            end
            if (speed_timer != 16'hFFFF)
                speed_timer = speed_timer + 16'd1;
            if (speed_hits >= speed_pulses || speed_timer >= speed_timeout) begin
                if (speed_timer != 0) begin
                    quot  = (64'(grid_length) * 64'(speed_hits) * 64'd1000) / 64'(speed_timer);
                    speed = (quot > 64'hFF_FFFF) ? 24'hFF_FFFF
                                                 : quot[rpsm_pkg::SPEED_W-1:0];
                end
                if (speed < 24'd5)
                    speed = '0;
                speed_timer       = '0;
                speed_hits        = '0;
                exp.speed_updated = 1'b1;
            end

            exp.position = position;
            exp.speed    = speed;
            expected_ticks.push_back(exp);
        endfunction

        function void check_tick(bit [31:0] pos, bit [rpsm_pkg::SPEED_W-1:0] spd,
                                 bit zer, bit upd);
            tick_result_t exp;
            if (expected_ticks.size() == 0) begin
                $error("unexpected result: position %0d speed %0d", pos, spd);
                errors++;
            end else begin
                exp = expected_ticks.pop_front();
                if (pos !== exp.position) begin
                    $error("position: expected %0d, actual %0d", exp.position, pos);
                    errors++;
                end
                if (spd !== exp.speed) begin
                    $error("speed: expected %0d, actual %0d", exp.speed, spd);
                    errors++;
                end
                if (zer !== exp.zeroed) begin
                    $error("zeroed: expected %0d, actual %0d", exp.zeroed, zer);
                    errors++;
                end
                if (upd !== exp.speed_updated) begin
                    $error("speed_updated: expected %0d, actual %0d", exp.speed_updated, upd);
                    errors++;
                end
            end
        endfunction
    endclass

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic               s_reset_level   = 1'b0;
    logic               s_count_level   = 1'b0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [31:0]        m_position;
    logic [rpsm_pkg::SPEED_W-1:0] m_speed;
    logic               m_zeroed;
    logic               m_speed_updated;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_index       = 8'd0;
    logic [31:0]        cfg_data        = 32'd0;

    position_speed_board board = new();

    bit no_idle     = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;
    int hold_left   = 0;
    bit wave_reset  = 1'b1;
    bit wave_count  = 1'b1;
    int run_reset   = 0;
    int run_count   = 0;

    raster_position_speed_meter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_reset_level   (s_reset_level),
        .s_count_level   (s_count_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_position      (m_position),
        .m_speed         (m_speed),
        .m_zeroed        (m_zeroed),
        .m_speed_updated (m_speed_updated),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #10 aclk = ~aclk;

    // result side: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                board.check_tick(m_position, m_speed, m_zeroed, m_speed_updated);
            if (hold_req && !hold_done) begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 24);
            end
        end
    end

    task automatic send_tick(input bit rlev, input bit clev);
        while (!no_idle && $urandom_range(99) < 24) begin
            s_valid       <= 1'b0;
            s_reset_level <= 1'($urandom);
            s_count_level <= 1'($urandom);
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_reset_level <= rlev;
        s_count_level <= clev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_tick(rlev, clev);
    endtask

    // no ticks in flight before a register write
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.expected_ticks.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_reg(idx, data);
    endtask

    task automatic configure(input logic [15:0] ft, input logic [1:0] idle,
                             input logic [3:0] need, input logic [15:0] win,
                             input logic [7:0] sp, input logic [15:0] tmo,
                             input logic [9:0] grid, input logic [31:0] start);
        write_reg(rpsm_pkg::REG_FILTER_TICKS,   32'(ft));
        write_reg(rpsm_pkg::REG_IDLE_LEVELS,    32'(idle));
        write_reg(rpsm_pkg::REG_RESET_NEEDED,   32'(need));
        write_reg(rpsm_pkg::REG_RESET_WINDOW,   32'(win));
        write_reg(rpsm_pkg::REG_SPEED_PULSES,   32'(sp));
        write_reg(rpsm_pkg::REG_SPEED_TIMEOUT,  32'(tmo));
        write_reg(rpsm_pkg::REG_GRID_LENGTH,    32'(grid));
        write_reg(rpsm_pkg::REG_START_POSITION, start);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // grating waveform: runs of random length with an occasional one-tick glitch
    function automatic bit wave_step(inout bit lev, inout int run, input int span);
        if (run <= 0) begin
            lev = ~lev;
            run = $urandom_range(span, 1);
        end
        run = run - 1;
        return ($urandom_range(99) < 6) ? ~lev : lev;
    endfunction

    task automatic run_ticks(input int n, input int span);
        bit r;
        bit c;
        for (int i = 0; i < n; i++) begin
            r = wave_step(wave_reset, run_reset, span);
            c = wave_step(wave_count, run_count, span);
            send_tick(r, c);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // startup level, same-tick zero and count, speed close at default settings
        for (int i = 0; i < 24; i++)
            send_tick(DIRECTED_LEVELS[47 - 2*i], DIRECTED_LEVELS[46 - 2*i]);

        settle();
        configure(16'd1, 2'd0, 4'd1, 16'd1, 8'd1, 16'd1, 10'd1, 32'd0);
        run_ticks(60, 3);

        settle();
        configure(16'd2, 2'd2, 4'd3, 16'd40, 8'd4, 16'd50, 10'd1023, 32'hFFFF_FFF0);
        run_ticks(80, 4);

        settle();
        configure(16'd3, 2'd1, 4'd2, 16'd200, 8'd8, 16'd300, 10'd517, $urandom);
        no_idle = 1'b1;
        run_ticks(100, 5);
        no_idle = 1'b0;

        settle();
        configure(16'd1, 2'd3, 4'd4, 16'd100, 8'd16, 16'd120, 10'd1, $urandom);
        hold_req = 1'b1;
        run_ticks(100, 3);

        // zero-valued registers, plus writes to unused indexes
        settle();
        write_reg(REG_NONE_FIRST, $urandom);
        write_reg(REG_NONE_LAST, $urandom);
        configure(16'd0, 2'($urandom), 4'd0, 16'd30, 8'd0, 16'd0, 10'd300, $urandom);
        run_ticks(40, 3);

        settle();
        configure(16'hFFFF, 2'd3, 4'd15, 16'hFFFF, 8'd255, 16'hFFFF, 10'd1023,
                  32'hFFFF_FFFF);
        run_ticks(30, 4);

        for (int k = 0; k < 3; k++) begin
            settle();
            configure(16'($urandom_range(4, 1)), 2'($urandom), 4'($urandom_range(4, 1)),
                      16'($urandom_range(300, 1)), 8'($urandom_range(20, 1)),
                      16'($urandom_range(200, 1)), 10'($urandom_range(1023, 1)),
                      $urandom);
            run_ticks(35, 5);
        end

        settle();
        repeat (60) @(posedge aclk);
        if (board.errors == 0 && board.expected_ticks.size() == 0)
            $display("raster_position_speed_meter: match");
        else
            $display("raster_position_speed_meter: mismatch");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("raster_position_speed_meter: mismatch");
        $finish;
    end

endmodule

// File: files.f
rtl/core/rpsm_pkg.sv
rtl/core/rpsm_div.sv
rtl/core/raster_position_speed_meter.sv
sim/raster_position_speed_meter_tb.sv
